>>> hw/rtl/pps_pkg.sv
// shared types, constants and the arctangent table of the pure pursuit steering block
package pps_pkg;

   localparam int DATA_W = 58;
   localparam int ANG_W  = 22;

   localparam logic signed [ANG_W-1:0] ANG_PI      = 22'sd205887;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 22'sd102944;
   localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 22'sd411775;
   localparam logic signed [DATA_W-1:0] GAIN_INV_Q30 = 58'sd652032874;
   localparam logic signed [18:0] STEER_MAX = 19'sd25736;

   localparam logic MODE_VEC = 1'b0;
   localparam logic MODE_ROT = 1'b1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [1:0] CSR_LOOKAHEAD   = 2'd0;
   localparam logic [1:0] CSR_WHEELBASE   = 2'd1;
   localparam logic [1:0] CSR_PATH_LENGTH = 2'd2;

   typedef struct packed {
      logic cap;
      logic wr;
      logic k_clr;
      logic k_inc;
      logic k_best;
      logic diff;
      logic sqx;
      logic sqy;
      logic eval;
      logic bear_go;
      logic alpha_ld;
      logic alpha_step;
      logic sin_go;
      logic num_ld;
      logic steer_go;
      logic out_ld;
   } cmd_type;

   typedef struct packed {
      logic k_last;
      logic walk_more;
      logic alpha_ok;
      logic cordic_busy;
   } sts_type;

   function automatic logic [15:0] atan_entry(input logic [4:0] i);
      logic [15:0] r;
      case (i)
         5'd0:    r = 16'd51472;
         5'd1:    r = 16'd30386;
         5'd2:    r = 16'd16055;
         5'd3:    r = 16'd8150;
         5'd4:    r = 16'd4091;
         5'd5:    r = 16'd2047;
         5'd6:    r = 16'd1024;
         5'd7:    r = 16'd512;
         5'd8:    r = 16'd256;
         5'd9:    r = 16'd128;
         5'd10:   r = 16'd64;
         5'd11:   r = 16'd32;
         5'd12:   r = 16'd16;
         5'd13:   r = 16'd8;
         5'd14:   r = 16'd4;
         5'd15:   r = 16'd2;
         5'd16:   r = 16'd1;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/pps_cordic.sv
// iterative cordic unit, one micro-rotation per cycle, vectoring or rotation mode
module pps_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  mode,
   input  logic signed [pps_pkg::DATA_W-1:0]     x0,
   input  logic signed [pps_pkg::DATA_W-1:0]     y0,
   input  logic signed [pps_pkg::ANG_W-1:0]      z0,
   output logic                                  busy,
   output logic signed [pps_pkg::DATA_W-1:0]     y_out,
   output logic signed [pps_pkg::ANG_W-1:0]      z_out
);
   import pps_pkg::*;

   logic signed [DATA_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ANG_W-1:0]  z_ff, z_in, a;
   logic [4:0]               cnt_ff, cnt_in;
   logic                     busy_ff, busy_in, mode_ff, mode_in;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      mode_in = mode_ff;
      xs      = x_ff >>> cnt_ff;
      ys      = y_ff >>> cnt_ff;
      a       = ANG_W'(atan_entry(cnt_ff));
      if (start) begin
         mode_in = mode;
         cnt_in  = '0;
         busy_in = 1'b1;
         x_in    = x0;
         y_in    = y0;
         z_in    = z0;
         if (mode == MODE_VEC) begin
            z_in = '0;
            if (x0 == '0 && y0 == '0) begin
               busy_in = 1'b0;
            end else if (x0 < 0) begin
               x_in = -x0;
               y_in = -y0;
               z_in = (y0 < 0) ? -ANG_PI : ANG_PI;
            end
         end
      end else if (busy_ff) begin
         if (mode_ff == MODE_VEC) begin
            if (y_ff > 0) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + a;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - a;
            end
         end else begin
            if (z_ff >= 0) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - a;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + a;
            end
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      mode_ff <= mode_in;
   end

   assign busy  = busy_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff < 5'(CORDIC_STEPS))
      else $error("cordic step count out of range");

endmodule

>>> hw/rtl/pps_datapath.sv
// path store, distance search, angle arithmetic, settings and result registers
module pps_datapath #(
   parameter int PATH_POINTS  = 1024,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pps_pkg::cmd_type      cmd,
   output pps_pkg::sts_type      sts,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [22:0]           csr_data,
   input  logic [9:0]            req_point_index,
   input  logic signed [23:0]    req_pos_x,
   input  logic signed [23:0]    req_pos_y,
   input  logic signed [15:0]    req_heading,
   output logic [9:0]            rsp_target_index,
   output logic signed [15:0]    rsp_steer_angle
);
   import pps_pkg::*;

   localparam int KW = (PATH_POINTS > 1) ? $clog2(PATH_POINTS) : 1;

   logic [47:0] mem [PATH_POINTS];
   logic [47:0] rdata_ff;

   logic [22:0] la_ff;
   logic [15:0] wb_ff;
   logic [10:0] pl_ff;

   logic signed [23:0] px_ff, py_ff;
   logic signed [15:0] hd_ff;
   logic [45:0]        la2_ff;
   logic [KW-1:0]      k_ff, k_in, best_ff, best_in, nlast;
   logic signed [24:0] dx_ff, dy_ff;
   logic [49:0]        sqx_ff, sqy_ff, bestd_ff, d;
   logic signed [49:0] prod;
   logic               upd;
   logic signed [ANG_W-1:0] alpha_ff, alpha_in;
   logic signed [50:0] num_ff;
   logic [9:0]         tgt_ff;
   logic signed [15:0] steer_ff;
   logic signed [18:0] rnd;
   logic [16:0]        pl_ext;

   logic                     c_start, c_mode, c_busy;
   logic signed [DATA_W-1:0] c_x0, c_y0, c_y;
   logic signed [ANG_W-1:0]  c_z0, c_z;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[KW'(req_point_index)] <= {req_pos_x, req_pos_y};
      end
      rdata_ff <= mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         la_ff <= 23'd2048;
         wb_ff <= 16'd2048;
         pl_ff <= 11'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LOOKAHEAD:   la_ff <= csr_data;
            CSR_WHEELBASE:   wb_ff <= csr_data[15:0];
            CSR_PATH_LENGTH: pl_ff <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pl_ext = 17'(pl_ff);
      if (pl_ext == '0) begin
         nlast = '0;
      end else if (pl_ext > 17'(PATH_POINTS)) begin
         nlast = KW'(PATH_POINTS - 1);
      end else begin
         nlast = KW'(pl_ext - 17'd1);
      end
   end

   assign d    = sqx_ff + sqy_ff;
   assign upd  = (k_ff == '0) || (d < bestd_ff);
   assign prod = cmd.sqx ? dx_ff * dx_ff : dy_ff * dy_ff;

   always_comb begin
      best_in = (cmd.eval && upd) ? k_ff : best_ff;
      k_in    = k_ff;
      if (cmd.k_clr) begin
         k_in = '0;
      end else if (cmd.k_best) begin
         k_in = best_in;
      end else if (cmd.k_inc) begin
         k_in = k_ff + KW'(1);
      end
   end

   always_comb begin
      alpha_in = alpha_ff;
      if (cmd.alpha_ld) begin
         alpha_in = c_z - ({{6{hd_ff[15]}}, hd_ff} <<< 3);
      end else if (cmd.alpha_step) begin
         if (alpha_ff > ANG_PI) begin
            alpha_in = alpha_ff - ANG_TWO_PI;
         end else if (alpha_ff < -ANG_PI) begin
            alpha_in = alpha_ff + ANG_TWO_PI;
         end else if (alpha_ff > ANG_HALF_PI) begin
            alpha_in = ANG_PI - alpha_ff;
         end else if (alpha_ff < -ANG_HALF_PI) begin
            alpha_in = -ANG_PI - alpha_ff;
         end
      end
   end

   assign rnd = 19'((c_z + 22'sd4) >>> 3);

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         px_ff  <= req_pos_x;
         py_ff  <= req_pos_y;
         hd_ff  <= req_heading;
         la2_ff <= la_ff * la_ff;
      end
      if (cmd.diff) begin
         dx_ff <= 25'(signed'(rdata_ff[47:24])) - 25'(px_ff);
         dy_ff <= 25'(signed'(rdata_ff[23:0])) - 25'(py_ff);
      end
      if (cmd.sqx) begin
         sqx_ff <= 50'(prod);
      end
      if (cmd.sqy) begin
         sqy_ff <= 50'(prod);
      end
      if (cmd.eval && upd) begin
         bestd_ff <= d;
      end
      if (cmd.num_ld) begin
         num_ff <= $signed({1'b0, wb_ff, 1'b0}) * $signed(c_y[32:0]);
      end
      if (cmd.out_ld) begin
         tgt_ff <= 10'(k_ff);
         if (rnd > STEER_MAX) begin
            steer_ff <= 16'(STEER_MAX);
         end else if (rnd < -STEER_MAX) begin
            steer_ff <= 16'(-STEER_MAX);
         end else begin
            steer_ff <= 16'(rnd);
         end
      end
      best_ff  <= best_in;
      alpha_ff <= alpha_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

   always_comb begin
      c_start = cmd.bear_go || cmd.sin_go || cmd.steer_go;
      c_mode  = cmd.sin_go ? MODE_ROT : MODE_VEC;
      c_z0    = alpha_ff;
      if (cmd.sin_go) begin
         c_x0 = GAIN_INV_Q30;
         c_y0 = '0;
      end else if (cmd.steer_go) begin
         c_x0 = {5'b0, la_ff, 30'b0};
         c_y0 = {{7{num_ff[50]}}, num_ff};
      end else begin
         c_x0 = {{3{dx_ff[24]}}, dx_ff, 30'b0};
         c_y0 = {{3{dy_ff[24]}}, dy_ff, 30'b0};
      end
   end

   pps_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (c_start),
      .mode  (c_mode),
      .x0    (c_x0),
      .y0    (c_y0),
      .z0    (c_z0),
      .busy  (c_busy),
      .y_out (c_y),
      .z_out (c_z)
   );

   always_comb begin
      sts.k_last      = (k_ff == nlast);
      sts.walk_more   = ({4'b0, la2_ff} > d) && (k_ff != nlast);
      sts.alpha_ok    = (alpha_ff <= ANG_PI) && (alpha_ff >= -ANG_PI);
      sts.cordic_busy = c_busy;
   end

   assign rsp_target_index = tgt_ff;
   assign rsp_steer_angle  = steer_ff;

endmodule

>>> hw/rtl/pps_ctrl.sv
// sequencer for loads, the nearest point scan, the forward walk and the cordic passes
module pps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  pps_pkg::sts_type      sts,
   output pps_pkg::cmd_type      cmd,
   input  logic                  slot_ok
);
   import pps_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_DIFF  = 4'd2;
   localparam logic [3:0] S_SQX   = 4'd3;
   localparam logic [3:0] S_SQY   = 4'd4;
   localparam logic [3:0] S_EVAL  = 4'd5;
   localparam logic [3:0] S_BEAR  = 4'd6;
   localparam logic [3:0] S_BWAIT = 4'd7;
   localparam logic [3:0] S_WRAP  = 4'd8;
   localparam logic [3:0] S_SIN   = 4'd9;
   localparam logic [3:0] S_SWAIT = 4'd10;
   localparam logic [3:0] S_NUM   = 4'd11;
   localparam logic [3:0] S_STEER = 4'd12;
   localparam logic [3:0] S_TWAIT = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       walk_ff, walk_in, rsp_valid_ff, rsp_valid_in, accept, rsp_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_LOAD) begin
                  cmd.wr = slot_ok;
               end else begin
                  cmd.cap   = 1'b1;
                  cmd.k_clr = 1'b1;
                  walk_in   = 1'b0;
                  state_in  = S_RD;
               end
            end
         end
         S_RD:   state_in = S_DIFF;
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd.sqx  = 1'b1;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.sqy  = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!walk_ff) begin
               cmd.eval = 1'b1;
               if (sts.k_last) begin
                  cmd.k_best = 1'b1;
                  walk_in    = 1'b1;
               end else begin
                  cmd.k_inc = 1'b1;
               end
               state_in = S_RD;
            end else if (sts.walk_more) begin
               cmd.k_inc = 1'b1;
               state_in  = S_RD;
            end else begin
               state_in = S_BEAR;
            end
         end
         S_BEAR: begin
            cmd.bear_go = 1'b1;
            state_in    = S_BWAIT;
         end
         S_BWAIT: begin
            if (!sts.cordic_busy) begin
               cmd.alpha_ld = 1'b1;
               state_in     = S_WRAP;
            end
         end
         S_WRAP: begin
            cmd.alpha_step = 1'b1;
            if (sts.alpha_ok) begin
               state_in = S_SIN;
            end
         end
         S_SIN: begin
            cmd.sin_go = 1'b1;
            state_in   = S_SWAIT;
         end
         S_SWAIT: begin
            if (!sts.cordic_busy) begin
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            cmd.num_ld = 1'b1;
            state_in   = S_STEER;
         end
         S_STEER: begin
            cmd.steer_go = 1'b1;
            state_in     = S_TWAIT;
         end
         S_TWAIT: begin
            if (!sts.cordic_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               cmd.out_ld   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         walk_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

   a_idle_cordic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !sts.cordic_busy)
      else $error("cordic running while idle");

   a_walk_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && !walk_ff && sts.k_last) |=> (walk_ff && state_ff == S_RD))
      else $error("scan did not hand over to the walk");

   a_load_no_run: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_LOAD) |=> (state_ff == S_IDLE))
      else $error("load transfer started a query");

endmodule

>>> hw/rtl/pure_pursuit_steering.sv
// top level of the pure pursuit steering block
// Usage:
//  req_ channel: kind 0 writes waypoint (pos_x, pos_y) to slot point_index and
//  gives no result (slots at or above PATH_POINTS are dropped); kind 1 is a query
//  with the robot position and heading and gives one rsp_ transfer.
//  csr_ port: index 0 lookahead, 1 wheelbase, 2 path_length; write only while idle.
//  A load does not raise req_stall. A query holds req_stall high while it runs:
//  the nearest point scan over n = path_length points (0 taken as 1, capped at
//  PATH_POINTS), the forward walk over the points it visits (at least one, at
//  most n), three passes of the shared cordic unit, each with its start state,
//  the angle wrapping, the numerator product and the result load. req_stall
//  falls in the same cycle as rsp_valid rises, so the next item can be taken
//  while the result is still shown.
//  The result waits in an output register; loads are still taken while
//  rsp_stall holds it, a second query finishes then waits for the register.
//  Reset clears the control and the settings (lookahead 2048, wheelbase 2048,
//  path_length 1); path contents are undefined until written.
module pure_pursuit_steering #(
   parameter int PATH_POINTS  = 1024,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [9:0]          req_point_index,
   input  logic signed [23:0]  req_pos_x,
   input  logic signed [23:0]  req_pos_y,
   input  logic signed [15:0]  req_heading,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [9:0]          rsp_target_index,
   output logic signed [15:0]  rsp_steer_angle,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [22:0]         csr_data
);
   import pps_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    slot_ok;

   assign slot_ok = 17'(req_point_index) < 17'(PATH_POINTS);

   pps_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .sts             (sts),
      .cmd             (cmd),
      .slot_ok         (slot_ok)
   );

   pps_datapath #(
      .PATH_POINTS  (PATH_POINTS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_point_index  (req_point_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_heading      (req_heading),
      .rsp_target_index (rsp_target_index),
      .rsp_steer_angle  (rsp_steer_angle)
   );

endmodule

>>> bench/tb.sv
// testbench of the pure pursuit steering block: directed and random waypoint loads and queries
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pps_pkg::*;

   localparam int IDLE_LIMIT = 100000;
   localparam longint TWO_PI_16 = 411775;
   localparam longint PI_16 = 205887;
   localparam longint HALF_PI_16 = 102944;
   localparam longint ARC_STEP [0:15] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                          256, 128, 64, 32, 16, 8, 4, 2};

   typedef struct {
      logic [9:0]         target;
      logic signed [15:0] steer;
   } steer_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = KIND_LOAD;
   logic [9:0] req_point_index = '0;
   logic signed [23:0] req_pos_x = '0;
   logic signed [23:0] req_pos_y = '0;
   logic signed [15:0] req_heading = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [9:0] rsp_target_index;
   logic signed [15:0] rsp_steer_angle;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_LOOKAHEAD;
   logic [22:0] csr_data = '0;

   longint way_x [0:1023];
   longint way_y [0:1023];
   longint lookahead_m = 2048;
   longint wheelbase_m = 2048;
   longint path_len_m = 1;
   steer_result_type steer_pending [$];
   int errors = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;

   pure_pursuit_steering dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 17);
   end

   // transfer checker
   always @(posedge clock) begin
      steer_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (steer_pending.size() == 0) begin
            $display("%0t unexpected result index %0d steer %0d", $time,
                     rsp_target_index, rsp_steer_angle);
            errors++;
         end else begin
            e = steer_pending.pop_front();
            if (e.target !== rsp_target_index) begin
               $display("%0t target index expected %0d actual %0d", $time, e.target,
                        rsp_target_index);
               errors++;
            end
            if (e.steer !== rsp_steer_angle) begin
               $display("%0t steer angle expected %0d actual %0d", $time, e.steer,
                        rsp_steer_angle);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic longint vector_angle(longint y, longint x);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y < 0) ? -PI_16 : PI_16;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += ARC_STEP[i];
         end else begin
            x -= ys; y += xs; z -= ARC_STEP[i];
         end
      end
      return z;
   endfunction

   function automatic longint sine_q30(longint a);
      longint x, y, xs, ys;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (a >= 0) begin
            x -= ys; y += xs; a -= ARC_STEP[i];
         end else begin
            x += ys; y -= xs; a += ARC_STEP[i];
         end
      end
      return y;
   endfunction

   function automatic longint range2(int k, longint rx, longint ry);
      longint dx, dy;
      dx = way_x[k] - rx;
      dy = way_y[k] - ry;
      return dx * dx + dy * dy;
   endfunction

   function automatic steer_result_type pursue(longint rx, longint ry, longint hd);
      steer_result_type r;
      int n, best;
      longint bestd, d, alpha, delta;
      n = path_len_m < 1 ? 1 : (path_len_m > 1024 ? 1024 : int'(path_len_m));
      best = 0;
      bestd = range2(0, rx, ry);
      for (int k = 1; k < n; k++) begin
         d = range2(k, rx, ry);
         if (d < bestd) begin
            bestd = d;
            best = k;
         end
      end
      while (lookahead_m * lookahead_m > range2(best, rx, ry) && best < n - 1)
         best++;
      alpha = vector_angle((way_y[best] - ry) <<< 30, (way_x[best] - rx) <<< 30) - hd * 8;
      while (alpha > PI_16) alpha -= TWO_PI_16;
      while (alpha < -PI_16) alpha += TWO_PI_16;
      if (alpha > HALF_PI_16) alpha = PI_16 - alpha;
      else if (alpha < -HALF_PI_16) alpha = -PI_16 - alpha;
      delta = (vector_angle(2 * wheelbase_m * sine_q30(alpha), lookahead_m <<< 30) + 4) >>> 3;
      if (delta > 25736) delta = 25736;
      if (delta < -25736) delta = -25736;
      r.target = best[9:0];
      r.steer = delta[15:0];
      return r;
   endfunction

   task automatic send_item(logic kind, int slot, int x, int y, int hd);
      logic signed [23:0] x24, y24;
      logic signed [15:0] h16;
      steer_result_type exp_r;
      x24 = 24'(x);
      y24 = 24'(y);
      h16 = 16'(hd);
      if (!calm && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_point_index <= slot[9:0];
      req_pos_x <= x24;
      req_pos_y <= y24;
      req_heading <= h16;
      do @(posedge clock); while (req_stall);
      if (kind == KIND_LOAD) begin
         way_x[slot[9:0]] = longint'(x24);
         way_y[slot[9:0]] = longint'(y24);
      end else begin
         exp_r = pursue(longint'(x24), longint'(y24), longint'(h16));
         steer_pending.insert(steer_pending.size(), exp_r);
      end
   endtask

   task automatic write_reg(logic [1:0] idx, int value);
      req_valid <= 1'b0;
      while (steer_pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[22:0];
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_LOOKAHEAD:   lookahead_m = longint'(value & 32'h7FFFFF);
         CSR_WHEELBASE:   wheelbase_m = longint'(value & 32'hFFFF);
         CSR_PATH_LENGTH: path_len_m = longint'(value & 32'h7FF);
         default: ;
      endcase
   endtask

   function automatic int any24();
      return int'($urandom_range(0, 16777215)) - 8388608;
   endfunction

   function automatic int any_heading();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   task automatic test_long_path();
      write_reg(CSR_PATH_LENGTH, 48);
      send_item(KIND_LOAD, 0, 8388607, -8388608, 0);
      send_item(KIND_LOAD, 1, -8388608, 8388607, 0);
      for (int k = 2; k < 48; k++)
         send_item(KIND_LOAD, k, any24(), any24(), any_heading());
      send_item(KIND_QUERY, 0, 0, 0, 0);
      send_item(KIND_QUERY, 0, any24(), any24(), any_heading());
      send_item(KIND_QUERY, 0, -8388608, 8388607, 25736);
      write_reg(CSR_PATH_LENGTH, 0);
      send_item(KIND_QUERY, 0, 8388607, -8388608, -25736);
   endtask

   task automatic test_corners();
      write_reg(CSR_PATH_LENGTH, 4);
      send_item(KIND_LOAD, 0, 0, 0, 0);
      send_item(KIND_LOAD, 1, 1500, 200, 0);
      send_item(KIND_LOAD, 2, 3000, -400, 0);
      send_item(KIND_LOAD, 3, 4500, 600, 0);
      send_item(KIND_QUERY, 0, 0, 0, 0);
      send_item(KIND_QUERY, 0, -8388608, -8388608, 32767);
      send_item(KIND_QUERY, 0, 8388607, 8388607, -32768);
      send_item(KIND_QUERY, 0, 100, -50, 25736);
      write_reg(CSR_LOOKAHEAD, 0);
      send_item(KIND_QUERY, 0, 0, 0, 0);
      send_item(KIND_QUERY, 0, 1000, 900, -25736);
      write_reg(CSR_WHEELBASE, 0);
      send_item(KIND_QUERY, 0, 1000, 900, 1234);
      write_reg(CSR_LOOKAHEAD, 8388607);
      write_reg(CSR_WHEELBASE, 65535);
      send_item(KIND_QUERY, 0, -3000, 2000, 12000);
      send_item(KIND_QUERY, 0, 4500, 600, -20000);
      write_reg(CSR_LOOKAHEAD, 1);
      send_item(KIND_QUERY, 0, 1499, 201, 0);
   endtask

   task automatic test_random_paths(int phases);
      int plen, ox, oy, sx, sy, k;
      for (int p = 0; p < phases; p++) begin
         calm = (p == 3);
         plen = $urandom_range(2, 24);
         write_reg(CSR_PATH_LENGTH, plen);
         case ($urandom_range(0, 5))
            0: write_reg(CSR_LOOKAHEAD, 0);
            1: write_reg(CSR_LOOKAHEAD, $urandom_range(1, 8388607));
            default: write_reg(CSR_LOOKAHEAD, $urandom_range(500, 10000));
         endcase
         case ($urandom_range(0, 4))
            0: write_reg(CSR_WHEELBASE, $urandom_range(0, 1) ? 0 : 65535);
            default: write_reg(CSR_WHEELBASE, $urandom_range(1, 65535));
         endcase
         ox = int'($urandom_range(0, 8388607)) - 4194304;
         oy = int'($urandom_range(0, 8388607)) - 4194304;
         sx = int'($urandom_range(0, 6000)) - 3000;
         sy = int'($urandom_range(0, 6000)) - 3000;
         for (int i = 0; i < plen; i++)
            send_item(KIND_LOAD, i, ox + i * sx + int'($urandom_range(0, 400)) - 200,
                      oy + i * sy + int'($urandom_range(0, 400)) - 200, any_heading());
         for (int q = 0; q < 14; q++) begin
            if ($urandom_range(99) < 15) begin
               send_item($urandom_range(0, 1) ? KIND_QUERY : KIND_LOAD,
                         $urandom_range(0, 1023), any24(), any24(), any_heading());
            end else begin
               k = $urandom_range(0, plen - 1);
               send_item(KIND_QUERY, 0, ox + k * sx + int'($urandom_range(0, 8000)) - 4000,
                         oy + k * sy + int'($urandom_range(0, 8000)) - 4000,
                         int'($urandom_range(0, 51472)) - 25736);
            end
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_long_path();
      test_corners();
      test_random_paths(8);
      req_valid <= 1'b0;
      while (steer_pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
